@@ src/gts_pkg.sv @@
// Shared types, codes and helpers of the triangle strip builder.
// No dependencies; every other file but gts_ram imports this package.
`default_nettype none

package gts_pkg;

  localparam int TRI_W      = 31;   // {front, c, b, a}
  localparam int TC_W       = 21;   // {seam, t, s}
  localparam int VID_W      = 10;
  localparam int TOTAL_W    = 12;
  localparam int SKIN_W     = 11;
  localparam int FRAC_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_NUM_W  = 27;
  localparam int DIV_STEPS  = 27;
  localparam int OP_W       = 5;

  localparam logic [1:0] FUNC_LOAD_TRI = 2'd0;
  localparam logic [1:0] FUNC_LOAD_TEX = 2'd1;
  localparam logic [1:0] FUNC_BEGIN    = 2'd2;
  localparam logic [1:0] FUNC_BUILD    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_USED = 2'd1;
  localparam logic [1:0] MARK_TEMP = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TRI   = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD_TEX   = 5'd2;
  localparam logic [OP_W-1:0] OP_CLR_INIT   = 5'd3;
  localparam logic [OP_W-1:0] OP_CLR        = 5'd4;
  localparam logic [OP_W-1:0] OP_SCAN_INIT  = 5'd5;
  localparam logic [OP_W-1:0] OP_SCAN_RD    = 5'd6;
  localparam logic [OP_W-1:0] OP_SCAN_NEXT  = 5'd7;
  localparam logic [OP_W-1:0] OP_CAND_FIRST = 5'd8;
  localparam logic [OP_W-1:0] OP_INIT_W     = 5'd9;
  localparam logic [OP_W-1:0] OP_GROW_RD    = 5'd10;
  localparam logic [OP_W-1:0] OP_GROW_NEXT  = 5'd11;
  localparam logic [OP_W-1:0] OP_GROW_ADD   = 5'd12;
  localparam logic [OP_W-1:0] OP_CLN_INIT   = 5'd13;
  localparam logic [OP_W-1:0] OP_CLN_RD     = 5'd14;
  localparam logic [OP_W-1:0] OP_CLN_WR     = 5'd15;
  localparam logic [OP_W-1:0] OP_CAND_END   = 5'd16;
  localparam logic [OP_W-1:0] OP_MARK_RD    = 5'd17;
  localparam logic [OP_W-1:0] OP_MARK_WR    = 5'd18;
  localparam logic [OP_W-1:0] OP_EM_INIT    = 5'd19;
  localparam logic [OP_W-1:0] OP_EM_RD      = 5'd20;
  localparam logic [OP_W-1:0] OP_EM_TEX     = 5'd21;
  localparam logic [OP_W-1:0] OP_EM_S       = 5'd22;
  localparam logic [OP_W-1:0] OP_EM_T       = 5'd23;
  localparam logic [OP_W-1:0] OP_EM_OUT     = 5'd24;
  localparam logic [OP_W-1:0] OP_DONE       = 5'd25;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] entry_index;
    logic [9:0]  corner_a;
    logic [9:0]  corner_b;
    logic [9:0]  corner_c;
    logic        front_facing;
    logic [9:0]  tex_s;
    logic [9:0]  tex_t;
    logic        seam_flag;
  } req_t;

  typedef struct packed {
    logic              done_res;
    logic signed [7:0] command_count;
    logic [9:0]        vertex_id;
    logic [17:0]       s_fraction;
    logic [17:0]       t_fraction;
    logic              last;
  } res_t;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic i_ge_n;
    logic used_nz;
    logic idx_is2;
    logic grow_stop;
    logic hit;
    logic hit_used;
    logic cln_end;
    logic last_cand;
    logic mark_end;
    logic em_end;
    logic div_busy;
  } stat_t;

  // corner k of a triangle word, k taken modulo 3 for k up to 5 (6 and 7 give corner c)
  function automatic logic [VID_W-1:0] corner_of(logic [TRI_W-1:0] t, logic [2:0] k);
    logic [VID_W-1:0] c;
    case (k)
      3'd0, 3'd3: c = t[9:0];
      3'd1, 3'd4: c = t[19:10];
      default:    c = t[29:20];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/greedy_triangle_stripifier_unit.sv @@
// Triangle strip/fan builder, top level: controller, datapath, assertions.
// Depends on gts_pkg, gts_ctrl, gts_dp.
//
// Requests are taken when start_i is high and busy_o is low. A begin request
// sweeps the used marks clear; after reset busy_o stays high for the same
// sweep. A build request scans for the next free triangle, then grows six
// candidates; each growth step re-reads the triangle store from the triangle
// after the start triangle onwards, and a candidate's temporary marks are then
// undone. Each emitted vertex runs the one-bit-a-cycle divider once for s
// and once for t. Results appear on res_o for one cycle with res_valid_o and
// cannot be held off. The register port is always ready.
`default_nettype none

module greedy_triangle_stripifier_unit import gts_pkg::*; #(
  parameter int MAX_TRIS       = 2048,
  parameter int MAX_VERTS      = 1024,
  parameter int MAX_STRIP_TRIS = 62
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire req_t                  req_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       res_valid_o,
  output res_t                       res_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  gts_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .func_i (req_i.func),
    .stat_i (stat),
    .busy_o,
    .cmd_o  (cmd)
  );

  gts_dp #(
    .MAX_TRIS       (MAX_TRIS),
    .MAX_VERTS      (MAX_VERTS),
    .MAX_STRIP_TRIS (MAX_STRIP_TRIS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .res_valid_o,
    .res_o
  );

  // results only come out of a request in progress
  a_res_in_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result outside a request");

  a_done_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.done_res |-> res_o.last && res_o.command_count == 8'sd0)
    else $error("malformed done result");

  a_vertex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.done_res |-> res_o.command_count != 8'sd0)
    else $error("vertex result without count");

endmodule

`default_nettype wire

@@ src/gts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/gts_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating Q2.16 result.
// Depends on gts_pkg.
`default_nettype none

module gts_div import gts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] num_i,
  input  wire logic [SKIN_W-1:0]    den_i,
  output logic                      busy_o,
  output logic [FRAC_W-1:0]         quo_o
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                 busy_q, busy_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d, quo_q, quo_d;
  logic [SKIN_W-1:0]    rem_q, rem_d, den_q, den_d;
  logic [SKIN_W:0]      r2;
  logic                 ge;

  always_comb begin
    r2     = {rem_q, num_q[DIV_NUM_W-1]};
    ge     = r2 >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_STEPS - 1);
      num_d  = num_i;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? SKIN_W'(r2 - {1'b0, den_q}) : SKIN_W'(r2);
      quo_d = {quo_q[DIV_NUM_W-2:0], ge};
      num_d = {num_q[DIV_NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = (|quo_q[DIV_NUM_W-1:FRAC_W]) ? '1 : quo_q[FRAC_W-1:0];

endmodule

`default_nettype wire

@@ src/gts_ctrl.sv @@
// Controller of the strip builder: sequences the datapath by one command a cycle.
// Depends on gts_pkg.
`default_nettype none

module gts_ctrl import gts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] func_i,
  input  wire stat_t      stat_i,
  output logic            busy_o,
  output cmd_t            cmd_o
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_LOAD_TRI  = 5'd1;
  localparam logic [4:0] S_LOAD_TEX  = 5'd2;
  localparam logic [4:0] S_CLR_INIT  = 5'd3;
  localparam logic [4:0] S_CLR       = 5'd4;
  localparam logic [4:0] S_SCAN_INIT = 5'd5;
  localparam logic [4:0] S_SCAN_RD   = 5'd6;
  localparam logic [4:0] S_SCAN_CHK  = 5'd7;
  localparam logic [4:0] S_INIT_W    = 5'd8;
  localparam logic [4:0] S_GROW_RD   = 5'd9;
  localparam logic [4:0] S_GROW_CHK  = 5'd10;
  localparam logic [4:0] S_CLN_RD    = 5'd11;
  localparam logic [4:0] S_CLN_WR    = 5'd12;
  localparam logic [4:0] S_CAND_END  = 5'd13;
  localparam logic [4:0] S_MARK_RD   = 5'd14;
  localparam logic [4:0] S_MARK_WR   = 5'd15;
  localparam logic [4:0] S_EM_RD     = 5'd16;
  localparam logic [4:0] S_EM_TEX    = 5'd17;
  localparam logic [4:0] S_EM_S      = 5'd18;
  localparam logic [4:0] S_WAIT_S    = 5'd19;
  localparam logic [4:0] S_EM_T      = 5'd20;
  localparam logic [4:0] S_WAIT_T    = 5'd21;
  localparam logic [4:0] S_EM_OUT    = 5'd22;
  localparam logic [4:0] S_DONE      = 5'd23;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NOP;
    cmd_o.accept = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          case (func_i)
            FUNC_LOAD_TRI: state_d = S_LOAD_TRI;
            FUNC_LOAD_TEX: state_d = S_LOAD_TEX;
            FUNC_BEGIN:    state_d = S_CLR_INIT;
            default:       state_d = S_SCAN_INIT;
          endcase
        end
      end
      S_LOAD_TRI: begin
        cmd_o.op = OP_LOAD_TRI;
        state_d  = S_IDLE;
      end
      S_LOAD_TEX: begin
        cmd_o.op = OP_LOAD_TEX;
        state_d  = S_IDLE;
      end
      S_CLR_INIT: begin
        cmd_o.op = OP_CLR_INIT;
        state_d  = S_CLR;
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_SCAN_INIT: begin
        cmd_o.op = OP_SCAN_INIT;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = stat_i.i_ge_n ? S_DONE : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat_i.used_nz) begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_SCAN_RD;
        end else begin
          cmd_o.op = OP_CAND_FIRST;
          state_d  = S_INIT_W;
        end
      end
      S_INIT_W: begin
        cmd_o.op = OP_INIT_W;
        if (stat_i.idx_is2) state_d = S_GROW_RD;
      end
      S_GROW_RD: begin
        if (stat_i.grow_stop) begin
          cmd_o.op = OP_CLN_INIT;
          state_d  = S_CLN_RD;
        end else begin
          cmd_o.op = OP_GROW_RD;
          state_d  = S_GROW_CHK;
        end
      end
      S_GROW_CHK: begin
        if (!stat_i.hit) begin
          cmd_o.op = OP_GROW_NEXT;
          state_d  = S_GROW_RD;
        end else if (stat_i.hit_used) begin
          cmd_o.op = OP_CLN_INIT;
          state_d  = S_CLN_RD;
        end else begin
          cmd_o.op = OP_GROW_ADD;
          state_d  = S_GROW_RD;
        end
      end
      // temporary marks are undone through the candidate's triangle list
      S_CLN_RD: begin
        if (stat_i.cln_end) begin
          state_d = S_CAND_END;
        end else begin
          cmd_o.op = OP_CLN_RD;
          state_d  = S_CLN_WR;
        end
      end
      S_CLN_WR: begin
        cmd_o.op = OP_CLN_WR;
        state_d  = S_CLN_RD;
      end
      S_CAND_END: begin
        cmd_o.op = OP_CAND_END;
        state_d  = stat_i.last_cand ? S_MARK_RD : S_INIT_W;
      end
      S_MARK_RD: begin
        if (stat_i.mark_end) begin
          cmd_o.op = OP_EM_INIT;
          state_d  = S_EM_RD;
        end else begin
          cmd_o.op = OP_MARK_RD;
          state_d  = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        cmd_o.op = OP_MARK_WR;
        state_d  = S_MARK_RD;
      end
      S_EM_RD: begin
        if (stat_i.em_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_EM_RD;
          state_d  = S_EM_TEX;
        end
      end
      S_EM_TEX: begin
        cmd_o.op = OP_EM_TEX;
        state_d  = S_EM_S;
      end
      S_EM_S: begin
        cmd_o.op = OP_EM_S;
        state_d  = S_WAIT_S;
      end
      S_WAIT_S: begin
        if (!stat_i.div_busy) state_d = S_EM_T;
      end
      S_EM_T: begin
        cmd_o.op = OP_EM_T;
        state_d  = S_WAIT_T;
      end
      S_WAIT_T: begin
        if (!stat_i.div_busy) state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd_o.op = OP_EM_OUT;
        state_d  = S_EM_RD;
      end
      S_DONE: begin
        cmd_o.op = OP_DONE;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // after reset the used marks are swept clear before the first request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

`default_nettype wire

@@ src/gts_dp.sv @@
// Datapath of the strip builder: stores, candidate buffers, scan registers,
// texcoord scaling and result register. Depends on gts_pkg, gts_ram, gts_div.
`default_nettype none

module gts_dp import gts_pkg::*; #(
  parameter int MAX_TRIS       = 2048,
  parameter int MAX_VERTS      = 1024,
  parameter int MAX_STRIP_TRIS = 62
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output stat_t                      stat_o,
  input  wire req_t                  req_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       res_valid_o,
  output res_t                       res_o
);

  localparam int TW = $clog2(MAX_TRIS);
  localparam int VW = $clog2(MAX_VERTS);
  localparam int BW = 7;   // two banks of 64 entries

  logic [OP_W-1:0] op;
  assign op = cmd_i.op;

  // configuration
  logic [TOTAL_W-1:0] total_q;
  logic [SKIN_W-1:0]  width_q, height_q, w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      width_q  <= SKIN_W'(1);
      height_q <= SKIN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOTAL:  total_q  <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i[SKIN_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[SKIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q == '0) ? SKIN_W'(1) : width_q;
  assign h_eff = (height_q == '0) ? SKIN_W'(1) : height_q;

  logic [TW:0] n;
  assign n = (32'(total_q) < 32'(MAX_TRIS)) ? (TW+1)'(total_q) : (TW+1)'(MAX_TRIS);

  // registers
  req_t            req_q;
  logic [TW:0]     i_q, j_q, scan_q;
  logic [TRI_W-1:0] st_q;
  logic            strip_q, sel_q, best_strip_q, vin_q, res_valid_q;
  logic [1:0]      sv_q;
  logic [VID_W-1:0] m1_q, m2_q, vid_q, t_q;
  logic [5:0]      count_q, best_len_q;
  logic [6:0]      idx_q;
  logic [FRAC_W-1:0] sfrac_q;
  res_t            res_q;

  // memory ports
  logic [TRI_W-1:0] tri_rd;
  logic [1:0]       used_rd;
  logic [TC_W-1:0]  tex_rd;
  logic [VID_W-1:0] vbuf_rd;
  logic [TW-1:0]    tbuf_rd;
  logic             used_we, vbuf_we, tbuf_we;
  logic [TW-1:0]    used_wa, tri_ra;
  logic [1:0]       used_wd;
  logic [BW-1:0]    vbuf_wa, tbuf_wa, tbuf_ra;
  logic [VID_W-1:0] vbuf_wd;
  logic [TW-1:0]    tbuf_wd;
  logic [31:0]      idx32, v32;

  assign idx32 = 32'(req_q.entry_index);
  assign v32   = 32'(vbuf_rd);
  assign tri_ra = (op == OP_SCAN_RD) ? i_q[TW-1:0] : j_q[TW-1:0];

  gts_ram #(.WIDTH(TRI_W), .DEPTH(MAX_TRIS)) u_tri_ram (
    .clk_i,
    .we_i    (op == OP_LOAD_TRI && idx32 < 32'(MAX_TRIS)),
    .waddr_i (idx32[TW-1:0]),
    .wdata_i ({req_q.front_facing, req_q.corner_c, req_q.corner_b, req_q.corner_a}),
    .raddr_i (tri_ra),
    .rdata_o (tri_rd)
  );

  gts_ram #(.WIDTH(2), .DEPTH(MAX_TRIS)) u_used_ram (
    .clk_i,
    .we_i    (used_we),
    .waddr_i (used_wa),
    .wdata_i (used_wd),
    .raddr_i (tri_ra),
    .rdata_o (used_rd)
  );

  gts_ram #(.WIDTH(TC_W), .DEPTH(MAX_VERTS)) u_tex_ram (
    .clk_i,
    .we_i    (op == OP_LOAD_TEX && idx32 < 32'(MAX_VERTS)),
    .waddr_i (idx32[VW-1:0]),
    .wdata_i ({req_q.seam_flag, req_q.tex_t, req_q.tex_s}),
    .raddr_i (v32[VW-1:0]),
    .rdata_o (tex_rd)
  );

  gts_ram #(.WIDTH(VID_W), .DEPTH(128)) u_vbuf_ram (
    .clk_i,
    .we_i    (vbuf_we),
    .waddr_i (vbuf_wa),
    .wdata_i (vbuf_wd),
    .raddr_i ({sel_q, idx_q[5:0]}),
    .rdata_o (vbuf_rd)
  );

  assign tbuf_ra = (op == OP_CLN_RD) ? {~sel_q, idx_q[5:0]} : {sel_q, idx_q[5:0]};

  gts_ram #(.WIDTH(TW), .DEPTH(128)) u_tbuf_ram (
    .clk_i,
    .we_i    (tbuf_we),
    .waddr_i (tbuf_wa),
    .wdata_i (tbuf_wd),
    .raddr_i (tbuf_ra),
    .rdata_o (tbuf_rd)
  );

  // neighbour match against the shared edge (m1, m2)
  logic [2:0]       mk;
  logic             face_ok, hit;
  logic [VID_W-1:0] nv;

  always_comb begin
    face_ok = tri_rd[TRI_W-1] == st_q[TRI_W-1];
    for (int k = 0; k < 3; k++) begin
      mk[k] = face_ok && corner_of(tri_rd, 3'(k)) == m1_q
                      && corner_of(tri_rd, 3'(k + 1)) == m2_q;
    end
    hit = |mk;
    if (mk[0])      nv = corner_of(tri_rd, 3'd2);
    else if (mk[1]) nv = corner_of(tri_rd, 3'd0);
    else            nv = corner_of(tri_rd, 3'd1);
  end

  logic [2:0]       rot;
  logic [VID_W-1:0] init_corner;
  assign rot         = {1'b0, sv_q} + idx_q[2:0];
  assign init_corner = corner_of(st_q, rot);

  always_comb begin
    used_we = 1'b0;
    used_wa = j_q[TW-1:0];
    used_wd = MARK_FREE;
    vbuf_we = 1'b0;
    vbuf_wa = {~sel_q, idx_q[5:0]};
    vbuf_wd = init_corner;
    tbuf_we = 1'b0;
    tbuf_wa = {~sel_q, 6'd0};
    tbuf_wd = i_q[TW-1:0];
    case (op)
      OP_CLR: used_we = 1'b1;
      OP_INIT_W: begin
        vbuf_we = 1'b1;
        tbuf_we = idx_q == 7'd0;
      end
      OP_GROW_ADD: begin
        used_we = 1'b1;
        used_wd = MARK_TEMP;
        vbuf_we = 1'b1;
        vbuf_wa = {~sel_q, count_q + 6'd2};
        vbuf_wd = nv;
        tbuf_we = 1'b1;
        tbuf_wa = {~sel_q, count_q};
        tbuf_wd = j_q[TW-1:0];
      end
      OP_CLN_WR: begin
        used_we = 1'b1;
        used_wa = tbuf_rd;
      end
      OP_MARK_WR: begin
        used_we = 1'b1;
        used_wa = tbuf_rd;
        used_wd = MARK_USED;
      end
      default: ;
    endcase
  end

  // texcoord scaling through the shared divider
  logic [TC_W-1:0]      tc;
  logic [SKIN_W-1:0]    s_sum;
  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num;
  logic [SKIN_W-1:0]    div_den;
  logic [FRAC_W-1:0]    quo;
  logic [6:0]           nv7;
  logic [7:0]           cmd_cnt;

  assign tc    = vin_q ? tex_rd : '0;
  assign s_sum = {1'b0, tc[9:0]}
               + ((!st_q[TRI_W-1] && tc[TC_W-1]) ? {1'b0, w_eff[SKIN_W-1:1]} : '0);
  assign div_start = op == OP_EM_S || op == OP_EM_T;
  assign div_num   = (op == OP_EM_S) ? {s_sum, 1'b1, 15'd0} : {1'b0, t_q, 1'b1, 15'd0};
  assign div_den   = (op == OP_EM_S) ? w_eff : h_eff;
  assign nv7       = {1'b0, best_len_q} + 7'd2;
  assign cmd_cnt   = best_strip_q ? {1'b0, nv7} : 8'(-{1'b0, nv7});

  gts_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      best_len_q   <= '0;
      best_strip_q <= 1'b0;
      sel_q        <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= op == OP_EM_OUT || op == OP_DONE;
      case (op)
        OP_CLR_INIT: scan_q <= '0;
        OP_CAND_FIRST: begin
          best_len_q   <= '0;
          best_strip_q <= 1'b0;
        end
        OP_CAND_END: begin
          scan_q <= i_q + 1'b1;
          if (count_q > best_len_q) begin
            best_len_q   <= count_q;
            best_strip_q <= strip_q;
            sel_q        <= ~sel_q;
          end
        end
        OP_DONE: scan_q <= n;
        default: ;
      endcase
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    case (op)
      OP_CLR_INIT:  j_q <= '0;
      OP_CLR:       j_q <= j_q + 1'b1;
      OP_SCAN_INIT: i_q <= scan_q;
      OP_SCAN_NEXT: i_q <= i_q + 1'b1;
      OP_CAND_FIRST: begin
        st_q    <= tri_rd;
        strip_q <= 1'b0;
        sv_q    <= 2'd0;
        idx_q   <= '0;
      end
      OP_INIT_W: begin
        idx_q   <= idx_q + 1'b1;
        count_q <= 6'd1;
        j_q     <= i_q + 1'b1;
        if (strip_q) begin
          m1_q <= corner_of(st_q, {1'b0, sv_q} + 3'd2);
          m2_q <= corner_of(st_q, {1'b0, sv_q} + 3'd1);
        end else begin
          m1_q <= corner_of(st_q, {1'b0, sv_q});
          m2_q <= corner_of(st_q, {1'b0, sv_q} + 3'd2);
        end
      end
      OP_GROW_NEXT: j_q <= j_q + 1'b1;
      OP_GROW_ADD: begin
        if (!strip_q || count_q[0]) m2_q <= nv;
        else                        m1_q <= nv;
        count_q <= count_q + 1'b1;
        j_q     <= i_q + 1'b1;
      end
      OP_CLN_INIT: idx_q <= 7'd1;
      OP_CLN_WR:   idx_q <= idx_q + 1'b1;
      OP_CAND_END: begin
        idx_q <= '0;
        if (sv_q == 2'd2) begin
          sv_q    <= 2'd0;
          strip_q <= 1'b1;
        end else begin
          sv_q <= sv_q + 1'b1;
        end
      end
      OP_MARK_WR: idx_q <= idx_q + 1'b1;
      OP_EM_INIT: idx_q <= '0;
      OP_EM_TEX: begin
        vid_q <= vbuf_rd;
        vin_q <= v32 < 32'(MAX_VERTS);
      end
      OP_EM_S: t_q <= tc[19:10];
      OP_EM_T: sfrac_q <= quo;
      OP_EM_OUT: begin
        idx_q <= idx_q + 1'b1;
        res_q <= '{done_res: 1'b0, command_count: cmd_cnt, vertex_id: vid_q,
                   s_fraction: sfrac_q, t_fraction: quo, last: idx_q == nv7 - 7'd1};
      end
      OP_DONE: res_q <= '{done_res: 1'b1, command_count: '0, vertex_id: '0,
                          s_fraction: '0, t_fraction: '0, last: 1'b1};
      default: ;
    endcase
  end

  assign stat_o.clr_last  = j_q == (TW+1)'(MAX_TRIS - 1);
  assign stat_o.i_ge_n    = i_q >= n;
  assign stat_o.used_nz   = used_rd != MARK_FREE;
  assign stat_o.idx_is2   = idx_q == 7'd2;
  assign stat_o.grow_stop = count_q >= 6'(MAX_STRIP_TRIS) || j_q >= n;
  assign stat_o.hit       = hit;
  assign stat_o.hit_used  = used_rd != MARK_FREE;
  assign stat_o.cln_end   = idx_q >= {1'b0, count_q};
  assign stat_o.last_cand = strip_q && sv_q == 2'd2;
  assign stat_o.mark_end  = idx_q >= {1'b0, best_len_q};
  assign stat_o.em_end    = idx_q >= nv7;
  assign stat_o.div_busy  = div_busy;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ verif/tb_greedy_triangle_stripifier_unit.sv @@
// Self-checking testbench of the triangle strip/fan builder: loads meshes,
// runs build requests and checks every emitted vertex against a local model.
// Depends on gts_pkg and greedy_triangle_stripifier_unit.
`default_nettype none

module tb_greedy_triangle_stripifier_unit;
  import gts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTRI    = 2048;
  localparam int NVERT   = 1024;
  localparam int NSTRIP  = 62;
  localparam int NPOOL   = 12;
  localparam int LIMIT   = 3000000;

  class strip_scoreboard;
    logic [TRI_W-1:0]  tri_mem [NTRI];
    logic [TC_W-1:0]   tex_mem [NVERT];
    logic [1:0]        marks   [NTRI];
    logic [VID_W-1:0]  work_v  [NSTRIP+2];
    int                work_t  [NSTRIP];
    logic [VID_W-1:0]  best_v  [NSTRIP+2];
    int                best_t  [NSTRIP];
    int                scan_pos;
    int unsigned       total_reg, width_reg, height_reg;
    res_t              vertex_q [$];
    int                fails;
    bit                saw_done;

    function new();
      foreach (marks[i]) marks[i] = MARK_FREE;
      foreach (tri_mem[i]) tri_mem[i] = '0;
      foreach (tex_mem[i]) tex_mem[i] = '0;
      scan_pos = 0; total_reg = 0; width_reg = 1; height_reg = 1; fails = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_TOTAL:  total_reg  = d;
        CFG_WIDTH:  width_reg  = d[10:0];
        CFG_HEIGHT: height_reg = d[10:0];
        default: ;
      endcase
    endfunction

    function int eff_total();
      return (total_reg < NTRI) ? total_reg : NTRI;
    endfunction

    function logic [VID_W-1:0] vert_of(int t, int k);
      return tri_mem[t][10*(k%3) +: 10];
    endfunction

    function logic [FRAC_W-1:0] to_fraction(int unsigned v, int unsigned div);
      longint unsigned q;
      if (div == 0) div = 1;
      q = (longint'(2*v + 1) * 32768) / div;
      return (q > 262143) ? 18'h3FFFF : q[17:0];
    endfunction

    function int grow_candidate(int st, int sv, bit strip);
      int n, count, j, k;
      logic [VID_W-1:0] m1, m2, nv;
      logic face;
      bit going, added;
      n = eff_total();
      count = 1;
      face = tri_mem[st][30];
      going = 1;
      work_v[0] = vert_of(st, sv);
      work_v[1] = vert_of(st, sv + 1);
      work_v[2] = vert_of(st, sv + 2);
      work_t[0] = st;
      if (strip) begin
        m1 = vert_of(st, sv + 2); m2 = vert_of(st, sv + 1);
      end else begin
        m1 = vert_of(st, sv); m2 = vert_of(st, sv + 2);
      end
      while (going && count < NSTRIP) begin
        added = 0;
        for (j = st + 1; j < n && going && !added; j++) begin
          if (tri_mem[j][30] != face) continue;
          for (k = 0; k < 3; k++) begin
            if (vert_of(j, k) != m1 || vert_of(j, k + 1) != m2) continue;
            if (marks[j] != MARK_FREE) begin
              going = 0;
              break;
            end
            nv = vert_of(j, k + 2);
            if (!strip || count[0]) m2 = nv;
            else m1 = nv;
            work_v[count + 2] = nv;
            work_t[count] = j;
            count++;
            marks[j] = MARK_TEMP;
            added = 1;
            break;
          end
        end
        if (!added) going = 0;
      end
      for (j = 0; j < n; j++)
        if (marks[j] == MARK_TEMP) marks[j] = MARK_FREE;
      return count;
    endfunction

    // next strip or fan from the lowest free triangle at or after the scan position, or one done result
    function void compute_build();
      int n, i, len, best_len, nv, j;
      bit best_strip, back;
      logic [7:0] cmd;
      logic [TC_W-1:0] tc;
      int unsigned s, w;
      res_t r;
      n = eff_total();
      i = scan_pos;
      while (i < n && marks[i] != MARK_FREE) i++;
      if (i >= n) begin
        scan_pos = n;
        r = '0; r.done_res = 1; r.last = 1;
        vertex_q.push_back(r);
        saw_done = 1;
        return;
      end
      best_len = 0; best_strip = 0;
      for (int ty = 0; ty < 2; ty++)
        for (int sv = 0; sv < 3; sv++) begin
          len = grow_candidate(i, sv, ty == 1);
          if (len > best_len) begin
            best_len = len; best_strip = ty;
            best_v = work_v; best_t = work_t;
          end
        end
      for (j = 0; j < best_len; j++) marks[best_t[j] % NTRI] = MARK_USED;
      scan_pos = i + 1;
      nv = best_len + 2;
      cmd = best_strip ? 8'(nv) : 8'(-nv);
      back = (tri_mem[i][30] == 1'b0);
      w = (width_reg != 0) ? width_reg : 1;
      for (j = 0; j < nv; j++) begin
        tc = tex_mem[best_v[j]];
        s = tc[9:0];
        if (back && tc[20]) s += w / 2;
        r.done_res      = 0;
        r.command_count = cmd;
        r.vertex_id     = best_v[j];
        r.s_fraction    = to_fraction(s, w);
        r.t_fraction    = to_fraction(tc[19:10], height_reg);
        r.last          = (j + 1 == nv);
        vertex_q.push_back(r);
      end
    endfunction

    function void note_request(req_t q);
      case (q.func)
        FUNC_LOAD_TRI:
          tri_mem[q.entry_index] = {q.front_facing, q.corner_c, q.corner_b, q.corner_a};
        FUNC_LOAD_TEX:
          if (q.entry_index < NVERT)
            tex_mem[q.entry_index] = {q.seam_flag, q.tex_t, q.tex_s};
        FUNC_BEGIN: begin
          foreach (marks[i]) marks[i] = MARK_FREE;
          scan_pos = 0;
        end
        default: compute_build();
      endcase
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex result %h", a);
        fails++;
        return;
      end
      e = vertex_q.pop_front();
      if (a.done_res !== e.done_res) begin
        $error("done_res exp %0d got %0d", e.done_res, a.done_res); fails++;
      end
      if (a.command_count !== e.command_count) begin
        $error("command_count exp %0d got %0d", e.command_count, a.command_count); fails++;
      end
      if (a.vertex_id !== e.vertex_id) begin
        $error("vertex_id exp %0d got %0d", e.vertex_id, a.vertex_id); fails++;
      end
      if (a.s_fraction !== e.s_fraction) begin
        $error("s_fraction exp %0d got %0d", e.s_fraction, a.s_fraction); fails++;
      end
      if (a.t_fraction !== e.t_fraction) begin
        $error("t_fraction exp %0d got %0d", e.t_fraction, a.t_fraction); fails++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); fails++;
      end
    endfunction
  endclass

  logic                  clk, rst_n, start, busy, cfg_valid, cfg_ready, res_valid;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  req_t                  req;
  res_t                  res;
  strip_scoreboard       sb;
  int                    cycles;
  int                    pool_base;
  bit                    quiet;

  greedy_triangle_stripifier_unit u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .req_i(req),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .res_valid_o(res_valid), .res_o(res)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL greedy_triangle_stripifier_unit");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && res_valid) sb.check_result(res);

  // start stays high across back-to-back requests; it drops only on a gap
  task automatic send(req_t q);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= q;
    do @(posedge clk); while (busy);
    sb.note_request(q);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.vertex_q.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic set_regs(int total, int w, int h);
    drain();
    write_cfg(CFG_TOTAL, CFG_DATA_W'(total));
    write_cfg(CFG_WIDTH, CFG_DATA_W'(w));
    write_cfg(CFG_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic req_t rand_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  // vertex k of the pool whose texcoords are loaded
  function automatic logic [VID_W-1:0] pv(int k);
    return VID_W'(pool_base + k % NPOOL);
  endfunction

  task automatic load_tri(int idx, logic [VID_W-1:0] a, logic [VID_W-1:0] b,
                          logic [VID_W-1:0] c, bit f);
    req_t q;
    q = rand_req();
    q.func = FUNC_LOAD_TRI; q.entry_index = 11'(idx);
    q.corner_a = a; q.corner_b = b; q.corner_c = c; q.front_facing = f;
    send(q);
  endtask

  task automatic send_func(logic [1:0] f);
    req_t q;
    q = rand_req();
    q.func = f;
    send(q);
  endtask

  // kind 0 fan, 1 strip, 2 random triangles over a small vertex pool
  task automatic load_mesh(int n, int kind);
    bit f;
    f = $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      if (kind == 2 && $urandom_range(0, 3) == 0) f = ~f;
      case (kind)
        0: load_tri(k, pv(0), pv(1 + k % (NPOOL - 1)), pv(1 + (k + 1) % (NPOOL - 1)), f);
        1: if (k[0] == 0)
             load_tri(k, pv(k), pv(k + 1), pv(k + 2), f);
           else
             load_tri(k, pv(k + 1), pv(k), pv(k + 2), f);
        default: load_tri(k, pv($urandom_range(0, 5)), pv($urandom_range(0, 5)),
                          pv($urandom_range(0, 5)), f);
      endcase
    end
  endtask

  task automatic build_all(int n, bit noisy);
    req_t q;
    sb.saw_done = 0;
    send_func(FUNC_BEGIN);
    for (int k = 0; k < n + 2 && !sb.saw_done; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        q = rand_req();
        // stray triangle loads stay at or above the active count
        if (q.func == FUNC_LOAD_TRI) q.entry_index = 11'(n + $urandom_range(0, 2047 - n));
        send(q);
      end
      if (k == 1) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.vertex_q.size() != 0);
      end
      send_func(FUNC_BUILD);
    end
  endtask

  initial begin
    req_t q;
    int n, ws [4], hs [4];
    sb = new();
    cycles = 0; quiet = 0;
    rst_n = 1'b0; start = 1'b0; req = '0;
    cfg_valid = 1'b0; cfg_index = CFG_TOTAL; cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // meshes only use pool vertices, so every texcoord read has been loaded
    pool_base = $urandom_range(0, NVERT - NPOOL);
    for (int v = 0; v < NPOOL; v++) begin
      q = rand_req();
      q.func = FUNC_LOAD_TEX; q.entry_index = 11'(pool_base + v);
      if (v < 4) begin
        q.tex_s = (v[0]) ? 10'd1023 : 10'd0;
        q.tex_t = (v[1]) ? 10'd1023 : 10'd0;
      end
      send(q);
    end
    q = rand_req();
    q.func = FUNC_LOAD_TEX; q.entry_index = 11'd2047;
    send(q);

    // empty count: build before begin and after gives done only
    set_regs(0, 1, 1);
    send_func(FUNC_BUILD);
    send_func(FUNC_BEGIN);
    send_func(FUNC_BUILD);

    // long fan of 63 triangles; its rim wraps around the vertex pool
    set_regs(63, 1024, 1024);
    load_mesh(63, 0);
    build_all(63, 0);

    ws = '{1, 2047, 0, 2};
    hs = '{0, 3, 2047, 1};
    for (int p = 0; p < 4; p++) begin
      n = $urandom_range(2, 4);
      quiet = (p == 3);
      set_regs(n, ws[p], hs[p]);
      load_mesh(n, p % 3);
      build_all(n, p < 3);
    end

    start <= 1'b0;
    do @(posedge clk); while (sb.vertex_q.size() != 0 || busy);
    repeat (200) @(posedge clk);
    if (sb.fails == 0 && sb.vertex_q.size() == 0)
      $display("PASS greedy_triangle_stripifier_unit");
    else
      $display("FAIL greedy_triangle_stripifier_unit");
    $finish;
  end

endmodule

`default_nettype wire

@@ greedy_triangle_stripifier_unit.f @@
src/gts_pkg.sv
src/gts_ram.sv
src/gts_div.sv
src/gts_ctrl.sv
src/gts_dp.sv
src/greedy_triangle_stripifier_unit.sv
verif/tb_greedy_triangle_stripifier_unit.sv
